[sv/gfm_pkg.sv]
// Shared constants and types for the GF(2^128) multiplier.
package gfm_pkg;

    localparam int GFM_WIDTH = 128;          // field element width
    localparam int GFM_HALF = 64;            // width of one operand half
    localparam int GFM_STEPS_PER_CELL = 8;   // shift/add steps done by one cell
    localparam logic [7:0] GFM_REDUCE = 8'hE1;  // reflected x^7+x^2+x+1, top byte

    // Work item carried from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [GFM_WIDTH-1:0] a;   // multiplier, consumed from the top bit
        logic [GFM_WIDTH-1:0] v;   // multiplicand times x^k, reduced
        logic [GFM_WIDTH-1:0] r;   // partial product
    } gfm_item_t;

endpackage

[sv/gfm_cell.sv]
// One cell of the multiplier chain: a few shift-and-add steps, then a register.
module gfm_cell
    import gfm_pkg::*;
#(
    parameter int STEPS_PER_CELL = GFM_STEPS_PER_CELL
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  gfm_item_t item_in,
    output gfm_item_t item_out
);

    gfm_item_t item_reg;
    gfm_item_t item_next;

    always_comb begin
        logic [GFM_WIDTH-1:0] a_w;
        logic [GFM_WIDTH-1:0] v_w;
        logic [GFM_WIDTH-1:0] r_w;
        logic                 lsb;
        a_w = item_in.a;
        v_w = item_in.v;
        r_w = item_in.r;
        for (int i = 0; i < STEPS_PER_CELL; i++) begin
            if (a_w[GFM_WIDTH-1]) begin
                r_w = r_w ^ v_w;
            end
            lsb = v_w[0];
            v_w = v_w >> 1;
            if (lsb) begin
                v_w[GFM_WIDTH-1 -: 8] = v_w[GFM_WIDTH-1 -: 8] ^ GFM_REDUCE;
            end
            a_w = a_w << 1;
        end
        item_next.valid = item_in.valid;
        item_next.a     = a_w;
        item_next.v     = v_w;
        item_next.r     = r_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg.valid <= item_next.valid;
        end
        if (en) begin
            item_reg.a <= item_next.a;
            item_reg.v <= item_next.v;
            item_reg.r <= item_next.r;
        end
    end

    assign item_out = item_reg;

endmodule

[sv/gf128_field_multiplier.sv]
// Top level: pipelined GF(2^128) multiplier in the GCM bit convention.
//
// Multiplies two 128-bit field elements modulo x^128 + x^7 + x^2 + x + 1 with
// reflected bit order (bit 127 is the coefficient of x^0), as used by GHASH.
// One operand pair is taken per clock and one product leaves per clock while
// the chain is not held by a stalled output. The work runs down a chain of
// 128/STEPS_PER_CELL identical cells (16 by default); each cell does
// STEPS_PER_CELL shift-and-add steps and registers its result. The last
// cell's register is the output register. The whole chain advances together:
// when a product waits on a low m_tready, s_tready drops and the chain holds;
// otherwise a new transfer is taken every cycle. STEPS_PER_CELL must divide
// 128; it trades latency against the depth of XOR logic between registers.
// Reset clears only the valid flags.
module gf128_field_multiplier
    import gfm_pkg::*;
#(
    parameter int STEPS_PER_CELL = GFM_STEPS_PER_CELL
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input operands
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [4*GFM_HALF-1:0]  s_tdata,   // a_low, a_high, b_low, b_high
    // field product
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*GFM_HALF-1:0]  m_tdata    // prod_low, prod_high
);

    localparam int NUM_CELLS = GFM_WIDTH / STEPS_PER_CELL;

    gfm_item_t chain_in  [NUM_CELLS];
    gfm_item_t chain_out [NUM_CELLS];
    gfm_item_t head;
    logic      advance;

    // The chain moves whenever the output stage is empty or being drained
    assign advance  = !chain_out[NUM_CELLS-1].valid || m_tready;
    assign s_tready = advance;

    // Operand unpacking: a = {a_high, a_low}, b = {b_high, b_low}
    always_comb begin
        head.valid = s_tvalid;
        head.a     = {s_tdata[2*GFM_HALF-1:GFM_HALF], s_tdata[GFM_HALF-1:0]};
        head.v     = {s_tdata[4*GFM_HALF-1:3*GFM_HALF], s_tdata[3*GFM_HALF-1:2*GFM_HALF]};
        head.r     = '0;
    end

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        if (c == 0) begin : g_first
            assign chain_in[c] = head;
        end else begin : g_next
            assign chain_in[c] = chain_out[c-1];
        end

        gfm_cell #(
            .STEPS_PER_CELL(STEPS_PER_CELL)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .item_in (chain_in[c]),
            .item_out(chain_out[c])
        );
    end

    assign m_tvalid = chain_out[NUM_CELLS-1].valid;
    assign m_tdata  = chain_out[NUM_CELLS-1].r;

    // A product never shows right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("product valid right after reset");

    // A waiting product must hold off new operands
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    // Output valid comes only from the cell before it
    if (NUM_CELLS > 1) begin : g_chk
        a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
            (advance && !chain_out[NUM_CELLS-2].valid) |=> !m_tvalid)
            else $error("product appeared without a predecessor");
    end

endmodule
